// ===== rtl/tnmix_pkg.sv =====
// Shared types and constants of the four-channel tone and noise mixer.
`default_nettype none
package tnmix_pkg;

    localparam int DEF_PHASE_BITS = 13;
    localparam int DEF_GAIN_BITS  = 8;

    localparam int NUM_CH      = 4;
    localparam int CH_IDX_W    = 2;
    localparam int CHAN_W      = 14;
    localparam int ONE_Q12     = 4096;
    localparam int TRI_SHIFT   = 14;
    localparam int DUTY_W      = 14;
    localparam int STEP_W      = 12;
    localparam int MASTER_W    = 9;
    localparam int MASTER_FRAC = 8;
    localparam int LFSR_W      = 16;
    localparam int SAMPLE_W    = 16;
    localparam int SAMPLE_MAX  = 32767;
    localparam int SAMPLE_MIN  = -32768;
    localparam int S_TDATA_W   = 8;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [CFG_W-1:0]    GAINS_RESET  = 32'h4040_4040;
    localparam logic [MASTER_W-1:0] MASTER_RESET = 9'd77;
    localparam logic [DUTY_W-1:0]   DUTY_RESET   = 14'd4096;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 12'd1;

    // Channel positions in the enable mask and in a channel set.
    localparam int CH_PULSE_A  = 0;
    localparam int CH_PULSE_B  = 1;
    localparam int CH_TRIANGLE = 2;
    localparam int CH_NOISE    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_ENABLE = 3'd0,
        CFG_CHANNEL_GAINS  = 3'd1,
        CFG_MASTER_GAIN    = 3'd2,
        CFG_PULSE_A_DUTY   = 3'd3,
        CFG_PULSE_B_DUTY   = 3'd4,
        CFG_PULSE_A_STEP   = 3'd5,
        CFG_PULSE_B_STEP   = 3'd6,
        CFG_TRIANGLE_STEP  = 3'd7
    } cfg_index_t;

    typedef logic signed [CHAN_W-1:0] chan_val_t;
    typedef chan_val_t [NUM_CH-1:0] chan_set_t;

    typedef struct packed {
        logic [NUM_CH-1:0] enable;
        logic [DUTY_W-1:0] pulse_a_duty;
        logic [DUTY_W-1:0] pulse_b_duty;
        logic [STEP_W-1:0] pulse_a_step;
        logic [STEP_W-1:0] pulse_b_step;
        logic [STEP_W-1:0] triangle_step;
    } front_cfg_t;

    typedef struct packed {
        logic [CFG_W-1:0]    gains;
        logic [MASTER_W-1:0] master_gain;
    } back_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/tnmix_front.sv =====
// Request intake: phase accumulators, noise LFSR and per-channel Q.12 values.
`default_nettype none
module tnmix_front #(
    parameter int PHASE_BITS = tnmix_pkg::DEF_PHASE_BITS
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire tnmix_pkg::front_cfg_t          cfg,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [tnmix_pkg::S_TDATA_W-1:0] s_tdata,   // [0] sample_request
    input  wire logic                           q_full,
    output logic                                q_push,
    output tnmix_pkg::chan_set_t                q_push_data
);
    import tnmix_pkg::*;

    localparam int CMP_W = PHASE_BITS + DUTY_W;
    localparam int ADD_W = PHASE_BITS + STEP_W;
    localparam int TRI_W = PHASE_BITS + TRI_SHIFT;
    localparam logic [PHASE_BITS-1:0] HALF_PH = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam chan_val_t VAL_ONE = CHAN_W'(ONE_Q12);
    localparam chan_val_t VAL_MINUS_ONE = CHAN_W'(-ONE_Q12);

    logic [PHASE_BITS-1:0] phase_a_reg, phase_a_next;
    logic [PHASE_BITS-1:0] phase_b_reg, phase_b_next;
    logic [PHASE_BITS-1:0] phase_t_reg, phase_t_next;
    logic [LFSR_W-1:0]     lfsr_reg, lfsr_next, lfsr_step;
    logic                  request;
    logic                  a_high, b_high;
    logic [PHASE_BITS-1:0] tri_dist;
    logic [TRI_W-1:0]      tri_full;
    logic [CHAN_W:0]       tri_wide;
    logic [ADD_W-1:0]      sum_a, sum_b, sum_t;

    assign s_tready = !q_full;
    assign request  = s_tvalid && s_tready && s_tdata[0];

    always_comb begin
        a_high = CMP_W'(phase_a_reg) < CMP_W'(cfg.pulse_a_duty);
        b_high = CMP_W'(phase_b_reg) < CMP_W'(cfg.pulse_b_duty);

        // Distance from mid-phase, scaled so that a full half period spans 8192.
        tri_dist = (phase_t_reg >= HALF_PH) ? (phase_t_reg - HALF_PH)
                                            : (HALF_PH - phase_t_reg);
        tri_full = {tri_dist, {TRI_SHIFT{1'b0}}} >> PHASE_BITS;
        tri_wide = {1'b0, tri_full[CHAN_W-1:0]} - (CHAN_W+1)'(ONE_Q12);

        lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);

        q_push_data[CH_PULSE_A]  = cfg.enable[CH_PULSE_A] ?
                                   (a_high ? VAL_ONE : VAL_MINUS_ONE) : '0;
        q_push_data[CH_PULSE_B]  = cfg.enable[CH_PULSE_B] ?
                                   (b_high ? VAL_ONE : VAL_MINUS_ONE) : '0;
        q_push_data[CH_TRIANGLE] = cfg.enable[CH_TRIANGLE] ? tri_wide[CHAN_W-1:0] : '0;
        q_push_data[CH_NOISE]    = cfg.enable[CH_NOISE] ?
                                   (lfsr_step[0] ? VAL_ONE : VAL_MINUS_ONE) : '0;

        sum_a = {{STEP_W{1'b0}}, phase_a_reg} + {{PHASE_BITS{1'b0}}, cfg.pulse_a_step};
        sum_b = {{STEP_W{1'b0}}, phase_b_reg} + {{PHASE_BITS{1'b0}}, cfg.pulse_b_step};
        sum_t = {{STEP_W{1'b0}}, phase_t_reg} + {{PHASE_BITS{1'b0}}, cfg.triangle_step};

        phase_a_next = phase_a_reg;
        phase_b_next = phase_b_reg;
        phase_t_next = phase_t_reg;
        lfsr_next    = lfsr_reg;
        if (request) begin
            phase_a_next = sum_a[PHASE_BITS-1:0];
            phase_b_next = sum_b[PHASE_BITS-1:0];
            phase_t_next = sum_t[PHASE_BITS-1:0];
            // The noise register only moves on samples where noise is enabled.
            if (cfg.enable[CH_NOISE]) begin
                lfsr_next = lfsr_step;
            end
        end
    end

    assign q_push = request;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_a_reg <= '0;
            phase_b_reg <= '0;
            phase_t_reg <= '0;
            lfsr_reg    <= LFSR_SEED;
        end else begin
            phase_a_reg <= phase_a_next;
            phase_b_reg <= phase_b_next;
            phase_t_reg <= phase_t_next;
            lfsr_reg    <= lfsr_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tnmix_queue.sv =====
// Short queue of channel sets between the request intake and the mixer.
`default_nettype none
module tnmix_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire tnmix_pkg::chan_set_t push_data,
    output logic                      full,
    input  wire logic                 pop,
    output tnmix_pkg::chan_set_t      head,
    output logic                      empty
);
    import tnmix_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    chan_set_t          mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

endmodule
`default_nettype wire

// ===== rtl/tnmix_back.sv =====
// Mixer: gain multiply-accumulate over the channels, master gain and saturation.
`default_nettype none
module tnmix_back #(
    parameter int GAIN_BITS = tnmix_pkg::DEF_GAIN_BITS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire tnmix_pkg::back_cfg_t             cfg,
    input  wire tnmix_pkg::chan_set_t             q_head,
    input  wire logic                             q_empty,
    output logic                                  q_pop,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [tnmix_pkg::SAMPLE_W-1:0]        m_tdata     // [15:0] mixed_sample
);
    import tnmix_pkg::*;

    localparam int GX_W  = NUM_CH * GAIN_BITS + CFG_W;
    localparam int PRD_W = CHAN_W + GAIN_BITS + 1;
    localparam int ACC_W = GAIN_BITS + 16;
    localparam int SC_W  = ACC_W + MASTER_W + 1;
    localparam int SHIFT = GAIN_BITS + MASTER_FRAC;
    localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CH - 1);
    localparam logic signed [SC_W-1:0] SAT_MAX = SC_W'(SAMPLE_MAX);
    localparam logic signed [SC_W-1:0] SAT_MIN = SC_W'(SAMPLE_MIN);

    logic [GX_W-1:0]             gains_ext;
    logic [GAIN_BITS-1:0]        gain_w [NUM_CH];
    logic [GAIN_BITS-1:0]        gain_sel;
    logic signed [CHAN_W-1:0]    val_sel;
    logic signed [PRD_W-1:0]     prod;
    logic signed [ACC_W-1:0]     acc_base, acc_sum;
    logic signed [ACC_W-1:0]     acc_reg;
    logic [CH_IDX_W-1:0]         idx_reg, idx_next;
    logic                        mac_step, mac_last;

    logic                        a_valid_reg, a_valid_next;
    logic signed [ACC_W-1:0]     a_acc_reg;
    logic                        b_valid_reg, b_valid_next;
    logic signed [SC_W-1:0]      b_scaled_reg;
    logic signed [SC_W-1:0]      b_shifted;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0]         m_tdata_reg;
    logic                        out_free, b_free, a_free;
    logic                        a_move, b_move;

    assign gains_ext = {{(GX_W-CFG_W){1'b0}}, cfg.gains};

    // A gain field that lies above the register reads as zero bits.
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_gain
        assign gain_w[ch] = gains_ext[ch*GAIN_BITS +: GAIN_BITS];
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign b_free   = !b_valid_reg || out_free;
    assign a_free   = !a_valid_reg || b_free;
    assign b_move   = b_valid_reg && out_free;
    assign a_move   = a_valid_reg && b_free;

    // One channel per cycle on the shared multiplier, unless queue or stage a stall.
    always_comb begin
        gain_sel = gain_w[idx_reg];
        val_sel  = $signed(q_head[idx_reg]);
        prod     = val_sel * $signed({1'b0, gain_sel});
        acc_base = (idx_reg == '0) ? '0 : acc_reg;
        acc_sum  = acc_base + ACC_W'(prod);
        mac_last = (idx_reg == LAST_CH);
        mac_step = !q_empty && (!mac_last || a_free);
        idx_next = idx_reg;
        if (mac_step) begin
            idx_next = mac_last ? '0 : idx_reg + 1'b1;
        end
    end

    assign q_pop = mac_step && mac_last;

    always_comb begin
        a_valid_next = a_valid_reg;
        if (q_pop) begin
            a_valid_next = 1'b1;
        end else if (a_move) begin
            a_valid_next = 1'b0;
        end
        b_valid_next = b_valid_reg;
        if (a_move) begin
            b_valid_next = 1'b1;
        end else if (b_move) begin
            b_valid_next = 1'b0;
        end
        m_tvalid_next = m_tvalid_reg;
        if (b_move) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        // Arithmetic shift floors, matching the rounding of the mix.
        b_shifted = b_scaled_reg >>> SHIFT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            idx_reg      <= idx_next;
            a_valid_reg  <= a_valid_next;
            b_valid_reg  <= b_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mac_step) begin
            acc_reg <= acc_sum;
        end
        if (q_pop) begin
            a_acc_reg <= acc_sum;
        end
        if (a_move) begin
            b_scaled_reg <= SC_W'(a_acc_reg) * $signed({1'b0, cfg.master_gain});
        end
        if (b_move) begin
            if (b_shifted > SAT_MAX) begin
                m_tdata_reg <= SAT_MAX[SAMPLE_W-1:0];
            end else if (b_shifted < SAT_MIN) begin
                m_tdata_reg <= SAT_MIN[SAMPLE_W-1:0];
            end else begin
                m_tdata_reg <= b_shifted[SAMPLE_W-1:0];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An item stays at the queue head until its last channel is accumulated.
    a_head_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != '0) |-> !q_empty)
        else $error("channel index advanced without a queued item");

    a_pop_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (idx_reg == '0) && a_valid_reg)
        else $error("finished item did not reach the scale stage");

    a_scale_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (b_valid_reg && !out_free) |=> b_valid_reg && $stable(b_scaled_reg))
        else $error("scaled sample lost while the output stalled");

endmodule
`default_nettype wire

// ===== rtl/four_channel_tone_noise_mixer_unit.sv =====
// Top level of the four-channel tone and noise mixer with its register file.
//
// Each accepted s_tdata item with sample_request set yields one saturated
// 16-bit sample on the m_ side; an item with the bit clear yields nothing and
// leaves the oscillators untouched. The intake computes all four channel
// values in the accept cycle and parks them in a two-entry queue, so requests
// are taken one per cycle until that queue fills. The mixer then takes the
// four channels of a sample in turn on its single gain multiplier and starts
// the next sample only after the last channel; the sum then passes through
// the accumulator, scale and output registers to m_tvalid. Configuration
// writes take effect at once and should be made while no sample is in flight.
`default_nettype none
module four_channel_tone_noise_mixer_unit #(
    parameter int PHASE_BITS = tnmix_pkg::DEF_PHASE_BITS,
    parameter int GAIN_BITS  = tnmix_pkg::DEF_GAIN_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [tnmix_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [tnmix_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [tnmix_pkg::S_TDATA_W-1:0] s_tdata,   // [0] sample_request
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [tnmix_pkg::SAMPLE_W-1:0]       m_tdata    // [15:0] mixed_sample
);
    import tnmix_pkg::*;

    logic [NUM_CH-1:0]   enable_reg;
    logic [CFG_W-1:0]    gains_reg;
    logic [MASTER_W-1:0] master_reg;
    logic [DUTY_W-1:0]   duty_a_reg, duty_b_reg;
    logic [STEP_W-1:0]   step_a_reg, step_b_reg, step_t_reg;
    front_cfg_t          front_cfg;
    back_cfg_t           back_cfg;
    cfg_index_t          wr_index;
    logic                q_full, q_empty, q_push, q_pop;
    chan_set_t           q_push_data, q_head;

    assign wr_index = cfg_index_t'(cfg_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
            gains_reg  <= GAINS_RESET;
            master_reg <= MASTER_RESET;
            duty_a_reg <= DUTY_RESET;
            duty_b_reg <= DUTY_RESET;
            step_a_reg <= STEP_RESET;
            step_b_reg <= STEP_RESET;
            step_t_reg <= STEP_RESET;
        end else if (cfg_wr_en) begin
            unique case (wr_index)
                CFG_CHANNEL_ENABLE: enable_reg <= cfg_wdata[NUM_CH-1:0];
                CFG_CHANNEL_GAINS:  gains_reg  <= cfg_wdata;
                CFG_MASTER_GAIN:    master_reg <= cfg_wdata[MASTER_W-1:0];
                CFG_PULSE_A_DUTY:   duty_a_reg <= cfg_wdata[DUTY_W-1:0];
                CFG_PULSE_B_DUTY:   duty_b_reg <= cfg_wdata[DUTY_W-1:0];
                CFG_PULSE_A_STEP:   step_a_reg <= cfg_wdata[STEP_W-1:0];
                CFG_PULSE_B_STEP:   step_b_reg <= cfg_wdata[STEP_W-1:0];
                CFG_TRIANGLE_STEP:  step_t_reg <= cfg_wdata[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        front_cfg.enable        = enable_reg;
        front_cfg.pulse_a_duty  = duty_a_reg;
        front_cfg.pulse_b_duty  = duty_b_reg;
        front_cfg.pulse_a_step  = step_a_reg;
        front_cfg.pulse_b_step  = step_b_reg;
        front_cfg.triangle_step = step_t_reg;
        back_cfg.gains          = gains_reg;
        back_cfg.master_gain    = master_reg;
    end

    tnmix_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (front_cfg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    tnmix_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    tnmix_back #(
        .GAIN_BITS (GAIN_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (back_cfg),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
